// File: design/pcte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcte_pkg
// Shared types, CSR numbers and the CSR number decode for the trap emulator.
// ----------------------------------------------------------------------------
package pcte_pkg;

    localparam int CSR_COUNT = 36;
    localparam int CSR_IDX_W = 6;

    localparam logic [63:0] VENDOR_ID = 64'h0000_0000_00c5_e536;
    localparam logic [11:0] CODE_ECALL = 12'h000;
    localparam logic [11:0] CODE_SRET  = 12'h102;
    localparam logic [11:0] CODE_MRET  = 12'h302;

    localparam logic [CSR_IDX_W-1:0] IDX_SSTATUS   = 6'd3;
    localparam logic [CSR_IDX_W-1:0] IDX_STVEC     = 6'd7;
    localparam logic [CSR_IDX_W-1:0] IDX_SEPC      = 6'd10;
    localparam logic [CSR_IDX_W-1:0] IDX_MVENDORID = 6'd15;
    localparam logic [CSR_IDX_W-1:0] IDX_MSTATUS   = 6'd19;
    localparam logic [CSR_IDX_W-1:0] IDX_MTVEC     = 6'd24;
    localparam logic [CSR_IDX_W-1:0] IDX_MEPC      = 6'd28;

    localparam logic [1:0] MODE_U = 2'd0;
    localparam logic [1:0] MODE_S = 2'd1;
    localparam logic [1:0] MODE_M = 2'd2;

    localparam logic [2:0] F3_SYSTEM = 3'd0;
    localparam logic [2:0] F3_CSRW   = 3'd1;
    localparam logic [2:0] F3_CSRR   = 3'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_UNKNOWN = 2'd1;
    localparam logic [1:0] STAT_FAULT   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic                 hit;
        logic [CSR_IDX_W-1:0] idx;
    } t_csr_hit;

    typedef struct packed {
        logic                 rd_en;
        logic [CSR_IDX_W-1:0] rd_a;
        logic [CSR_IDX_W-1:0] rd_b;
        logic                 wr_en;
        logic [CSR_IDX_W-1:0] wr_addr;
        logic                 clear;
    } t_mem_req;

    function automatic t_csr_hit csr_lookup(input logic [11:0] code);
        t_csr_hit r;
        r.hit = 1'b1;
        case (code)
            12'h000: r.idx = 6'd0;
            12'h004: r.idx = 6'd1;
            12'h040: r.idx = 6'd2;
            12'h100: r.idx = 6'd3;
            12'h102: r.idx = 6'd4;
            12'h103: r.idx = 6'd5;
            12'h104: r.idx = 6'd6;
            12'h105: r.idx = 6'd7;
            12'h106: r.idx = 6'd8;
            12'h140: r.idx = 6'd9;
            12'h141: r.idx = 6'd10;
            12'h142: r.idx = 6'd11;
            12'h143: r.idx = 6'd12;
            12'h144: r.idx = 6'd13;
            12'h180: r.idx = 6'd14;
            12'hF11: r.idx = 6'd15;
            12'hF12: r.idx = 6'd16;
            12'hF13: r.idx = 6'd17;
            12'hF14: r.idx = 6'd18;
            12'h300: r.idx = 6'd19;
            12'h301: r.idx = 6'd20;
            12'h302: r.idx = 6'd21;
            12'h303: r.idx = 6'd22;
            12'h304: r.idx = 6'd23;
            12'h305: r.idx = 6'd24;
            12'h306: r.idx = 6'd25;
            12'h310: r.idx = 6'd26;
            12'h340: r.idx = 6'd27;
            12'h341: r.idx = 6'd28;
            12'h342: r.idx = 6'd29;
            12'h343: r.idx = 6'd30;
            12'h344: r.idx = 6'd31;
            12'h34A: r.idx = 6'd32;
            12'h34B: r.idx = 6'd33;
            12'h3A0: r.idx = 6'd34;
            12'h3B0: r.idx = 6'd35;
            default: begin
                r.hit = 1'b0;
                r.idx = 6'd0;
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] csr_reset_value(input logic [CSR_IDX_W-1:0] idx);
        return (idx == IDX_MVENDORID) ? VENDOR_ID : 64'd0;
    endfunction

endpackage
`default_nettype wire

// File: design/pcte_csr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcte_csr_mem
// CSR storage: 36 x 64 memory, two registered read ports, one write port.
// Per-entry valid bits give a clear of all entries back to reset values.
// ----------------------------------------------------------------------------
module pcte_csr_mem
    import pcte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_mem_req    i_req,
    input  wire logic [63:0] i_wr_data,
    output logic      [63:0] o_rd_data_a,
    output logic      [63:0] o_rd_data_b
);

    logic [63:0]          r_mem [CSR_COUNT];
    logic [CSR_COUNT-1:0] r_vld;
    logic [63:0]          r_q_a;
    logic [63:0]          r_q_b;
    logic                 r_qv_a;
    logic                 r_qv_b;
    logic [CSR_IDX_W-1:0] r_qi_a;
    logic [CSR_IDX_W-1:0] r_qi_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_q_a  <= r_mem[i_req.rd_a];
            r_q_b  <= r_mem[i_req.rd_b];
            r_qv_a <= r_vld[i_req.rd_a];
            r_qv_b <= r_vld[i_req.rd_b];
            r_qi_a <= i_req.rd_a;
            r_qi_b <= i_req.rd_b;
        end
    end

    // drop all entries back to reset values on reset or clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data_a = r_qv_a ? r_q_a : csr_reset_value(r_qi_a);
    assign o_rd_data_b = r_qv_b ? r_q_b : csr_reset_value(r_qi_b);

endmodule
`default_nettype wire

// File: design/privileged_csr_trap_emulator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// privileged_csr_trap_emulator
// Emulates ECALL, SRET, MRET, CSRW and CSRR against a virtual CSR file.
// ----------------------------------------------------------------------------
// Each trapped instruction first reads the CSR memory (two registered read
// ports), then in the execute state updates state and loads the result
// register, waiting while an earlier result is held by a stall. A new
// transfer is taken only while idle; a held result may still wait while
// the next one is accepted. Faults restore all CSRs to reset values.
module privileged_csr_trap_emulator
    import pcte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_instruction,
    input  wire logic [63:0] i_fault_pc,
    input  wire logic [63:0] i_source_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [63:0] o_next_pc,
    output logic      [31:0] o_read_value,
    output logic      [4:0]  o_dest_index,
    output logic             o_dest_write,
    output logic      [1:0]  o_status,
    output logic      [1:0]  o_mode_now
);

    t_state   r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic [31:0] r_inst;
    logic [63:0] r_pc;
    logic [63:0] r_src;
    t_csr_hit    r_hit;
    logic        r_out_valid;

    t_csr_hit    in_hit;
    t_mem_req    req;
    logic [CSR_IDX_W-1:0] rd_addr_a;
    logic [CSR_IDX_W-1:0] rd_addr_b;
    logic [63:0] wr_data;
    logic [63:0] rd_a, rd_b;
    logic        in_fire;
    logic        exec_done;

    logic [2:0]  f3;
    logic [11:0] code;
    logic [4:0]  rd;
    logic [1:0]  need;
    logic        fault;
    logic [63:0] n_pc;
    logic [31:0] n_rval;
    logic [4:0]  n_didx;
    logic        n_dwr;
    logic [1:0]  n_stat;

    assign in_fire   = i_in_valid && !o_in_stall;
    assign exec_done = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);
    assign in_hit    = csr_lookup(i_instruction[31:20]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_fire) n_state = ST_EXEC;
            ST_EXEC: if (exec_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
    end

    // read addresses from the incoming instruction and current mode
    always_comb begin
        rd_addr_a = in_hit.idx;
        rd_addr_b = IDX_SSTATUS;
        if (i_instruction[14:12] == F3_SYSTEM) begin
            case (i_instruction[31:20])
                CODE_ECALL: rd_addr_a = (r_mode == MODE_U) ? IDX_STVEC : IDX_MTVEC;
                CODE_SRET: begin
                    rd_addr_a = IDX_SEPC;
                    rd_addr_b = IDX_SSTATUS;
                end
                CODE_MRET: begin
                    rd_addr_a = IDX_MEPC;
                    rd_addr_b = IDX_MSTATUS;
                end
                default: rd_addr_a = in_hit.idx;
            endcase
        end
    end

    assign f3   = r_inst[14:12];
    assign code = r_inst[31:20];
    assign rd   = r_inst[11:7];
    assign need = (code[9:8] >= 2'd2) ? MODE_M : code[9:8];

    always_comb begin
        fault       = 1'b0;
        n_pc        = r_pc;
        n_rval      = '0;
        n_didx      = '0;
        n_dwr       = 1'b0;
        n_stat      = STAT_DONE;
        n_mode      = r_mode;
        req.rd_en   = in_fire;
        req.rd_a    = rd_addr_a;
        req.rd_b    = rd_addr_b;
        req.wr_en   = 1'b0;
        req.wr_addr = r_hit.idx;
        wr_data     = r_src;
        case (f3)
            F3_SYSTEM: begin
                if (code == CODE_ECALL) begin
                    if (r_mode == MODE_U) begin
                        n_mode      = MODE_S;
                        req.wr_en   = 1'b1;
                        req.wr_addr = IDX_SEPC;
                        wr_data     = r_pc;
                        n_pc        = rd_a;
                    end else if (r_mode == MODE_S) begin
                        n_mode      = MODE_M;
                        req.wr_en   = 1'b1;
                        req.wr_addr = IDX_MEPC;
                        wr_data     = r_pc;
                        n_pc        = rd_a;
                    end
                end else if (code == CODE_SRET) begin
                    if (r_mode != MODE_U) begin
                        n_pc   = rd_a;
                        n_mode = {1'b0, rd_b[8]};
                    end else begin
                        fault = 1'b1;
                    end
                end else if (code == CODE_MRET) begin
                    if (r_mode >= MODE_M) begin
                        n_pc   = rd_a;
                        n_mode = rd_b[12:11];
                    end else begin
                        fault = 1'b1;
                    end
                end else begin
                    fault = 1'b1;
                end
            end
            F3_CSRW, F3_CSRR: begin
                if (!r_hit.hit) begin
                    n_stat = STAT_UNKNOWN;
                end else begin
                    n_pc = r_pc + 64'd4;
                    if (r_mode >= need) begin
                        if (f3 == F3_CSRW) begin
                            req.wr_en = 1'b1;
                        end else begin
                            n_rval = rd_a[31:0];
                            n_didx = rd;
                            n_dwr  = (rd != 5'd0);
                        end
                    end else begin
                        fault = 1'b1;
                    end
                end
            end
            default: fault = 1'b1;
        endcase
        if (fault) begin
            n_mode    = MODE_M;
            n_stat    = STAT_FAULT;
            req.wr_en = 1'b0;
        end
        req.wr_en = req.wr_en && exec_done;
        req.clear = fault && exec_done;
    end

    pcte_csr_mem u_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_wr_data   (wr_data),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_M;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_done) begin
                r_mode      <= n_mode;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_inst <= i_instruction;
            r_pc   <= i_fault_pc;
            r_src  <= i_source_value;
            r_hit  <= in_hit;
        end
        if (exec_done) begin
            o_next_pc    <= n_pc;
            o_read_value <= n_rval;
            o_dest_index <= n_didx;
            o_dest_write <= n_dwr;
            o_status     <= n_stat;
            o_mode_now   <= n_mode;
        end
    end

    assign o_out_valid = r_out_valid;

    a_fault_to_machine: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_done && fault) |=> (r_mode == MODE_M))
        else $error("fault did not return to machine mode");
    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted transfer did not start execution");
    a_dest_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_dest_write) |-> (o_status == STAT_DONE && o_dest_index != 5'd0))
        else $error("register write flagged on a failed or rd zero result");
    a_no_write_on_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.clear |-> !req.wr_en)
        else $error("write issued together with clear");

endmodule
`default_nettype wire
